// File: hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes of the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 16;

    typedef logic [1:0] action_t;
    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_DELETE = 2'd1;
    localparam action_t ACT_READ   = 2'd2;
    localparam action_t ACT_NONE   = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_OOB   = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos_idx;
        logic [POS_W-1:0]   last_idx;
        logic [WORD_W-1:0]  word;
    } cell_cmd_t;

    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  value;
        logic               last;
    } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot; shifts, loads or rotates its word under the broadcast command.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                       clk,
    input  wire ple_pkg::cell_cmd_t         cmd,
    input  wire logic [ple_pkg::WORD_W-1:0] left_word,
    input  wire logic [ple_pkg::WORD_W-1:0] right_word,
    input  wire logic [ple_pkg::WORD_W-1:0] head_word,
    output logic      [ple_pkg::WORD_W-1:0] word
);

    localparam logic [ple_pkg::POS_W-1:0] MY_IDX = ple_pkg::POS_W'(INDEX);

    logic [ple_pkg::WORD_W-1:0] word_reg;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            ple_pkg::CELL_INSERT:
            begin
                if (MY_IDX == cmd.pos_idx)
                    word_reg <= cmd.word;
                else if (MY_IDX > cmd.pos_idx)
                    word_reg <= left_word;
            end
            ple_pkg::CELL_DELETE:
            begin
                if (MY_IDX >= cmd.pos_idx)
                    word_reg <= right_word;
            end
            ple_pkg::CELL_ROTATE:
            begin
                if (MY_IDX == cmd.last_idx)
                    word_reg <= head_word;
                else if (MY_IDX < cmd.last_idx)
                    word_reg <= right_word;
            end
            default:
            begin
                word_reg <= word_reg;
            end
        endcase
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// File: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one command per transaction: tuser = action,
//   tdata = value and position. Master channel returns result transactions:
//   tuser = status, tdata = entry word, tlast on the final result of a command.
//   On insert and delete every cell shifts or loads in parallel and one result
//   is queued. During a read-out the cell chain rotates once per cycle while the
//   queue has room, and cell 0 is queued each time the chain rotates.
//   A two-entry result queue separates the sides; the slave side takes a
//   command while one result still waits. When the receiver stalls the queue
//   fills, the read-out pauses, and tready drops.
//   Each result is registered in the queue before it reaches the master side.
//   Reset empties the list and the queue; cell contents are left as they are
//   and are only read after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [31:0] value, [47:32] position
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] value_res
    output logic      [1:0]  m_tuser,   // [1:0] status
    output logic             m_tlast
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int PW = ple_pkg::POS_W;
    localparam logic [PW:0] CAP_EXT = (PW+1)'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t  state_reg, state_next;
    logic [LW-1:0] length_reg, length_next;
    logic [LW-1:0] rd_cnt_reg, rd_cnt_next;

    ple_pkg::out_item_t fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    ple_pkg::cell_cmd_t  cmd;
    ple_pkg::out_item_t  push_item;
    logic                push;
    logic                pop;
    logic                accept;

    ple_pkg::action_t               in_action;
    logic [ple_pkg::WORD_W-1:0]     in_value;
    logic [PW-1:0]                  in_pos;
    logic [PW:0]                    pos_ext;
    logic [PW:0]                    len_ext;

    logic [ple_pkg::WORD_W-1:0] words [CAPACITY];

    assign in_action = s_tuser;
    assign in_value  = s_tdata[31:0];
    assign in_pos    = s_tdata[47:32];
    assign pos_ext   = {1'b0, in_pos};
    assign len_ext   = (PW+1)'(length_reg);

    assign s_tready = (state_reg == S_IDLE) && (cnt_reg != 2'd2);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;

    assign m_tuser = fifo_reg[rd_ptr_reg].status;
    assign m_tdata = fifo_reg[rd_ptr_reg].value;
    assign m_tlast = fifo_reg[rd_ptr_reg].last;

    always_comb
    begin
        state_next      = state_reg;
        length_next     = length_reg;
        rd_cnt_next     = rd_cnt_reg;
        push            = 1'b0;
        push_item       = '{status: ple_pkg::ST_OK, value: '0, last: 1'b1};
        cmd.op          = ple_pkg::CELL_HOLD;
        cmd.pos_idx     = in_pos - PW'(1);
        cmd.last_idx    = PW'(length_reg) - PW'(1);
        cmd.word        = in_value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    case (in_action)
                        ple_pkg::ACT_INSERT:
                        begin
                            if (in_pos == '0 || pos_ext > len_ext + (PW+1)'(1))
                                push_item.status = ple_pkg::ST_OOB;
                            else if (len_ext >= CAP_EXT)
                                push_item.status = ple_pkg::ST_FULL;
                            else
                            begin
                                cmd.op      = ple_pkg::CELL_INSERT;
                                length_next = length_reg + LW'(1);
                            end
                        end
                        ple_pkg::ACT_DELETE:
                        begin
                            if (length_reg == '0)
                                push_item.status = ple_pkg::ST_EMPTY;
                            else if (in_pos == '0 || pos_ext > len_ext)
                                push_item.status = ple_pkg::ST_OOB;
                            else
                            begin
                                cmd.op      = ple_pkg::CELL_DELETE;
                                length_next = length_reg - LW'(1);
                            end
                        end
                        ple_pkg::ACT_READ:
                        begin
                            if (length_reg == '0)
                                push_item.status = ple_pkg::ST_EMPTY;
                            else
                            begin
                                cmd.op          = ple_pkg::CELL_ROTATE;
                                push_item.value = words[0];
                                push_item.last  = (length_reg == LW'(1));
                                rd_cnt_next     = LW'(1);
                                if (length_reg != LW'(1))
                                    state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            push_item.status = ple_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (cnt_reg != 2'd2)
                begin
                    push            = 1'b1;
                    cmd.op          = ple_pkg::CELL_ROTATE;
                    push_item.value = words[0];
                    push_item.last  = (rd_cnt_reg == length_reg - LW'(1));
                    rd_cnt_next     = rd_cnt_reg + LW'(1);
                    if (push_item.last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ple_pkg::WORD_W-1:0] left_w;
        logic [ple_pkg::WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = words[i+1];
        end

        ple_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_word  (left_w),
            .right_word (right_w),
            .head_word  (words[0]),
            .word       (words[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            length_reg <= '0;
            rd_cnt_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
            rd_cnt_reg <= rd_cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= push_item;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (LW+1)'(length_reg) <= (LW+1)'(CAPACITY))
        else $error("list length beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (rd_cnt_reg < length_reg && !s_tready))
        else $error("read-out counter out of range or command taken during read-out");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && cnt_reg == 2'd2) |-> 1'b0)
        else $error("push into full result queue");

endmodule

`default_nettype wire
